// ===== sv/uvs_pkg.sv =====
// ============================================================================
// uvs_pkg
// Shared types and constants of the UV-sphere mesh generator: register
// indexes, CORDIC constants and the control word that follows an item.
// ============================================================================
`default_nettype none

package uvs_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_SEG_X  = 2'd1,
        REG_SEG_Y  = 2'd2
    } reg_idx_t;

    localparam int CORDIC_STEPS = 24;
    localparam int XW           = 34;   // CORDIC x/y width, Q2.30 with headroom
    localparam int AW           = 33;   // CORDIC residual angle, 1/2^32 turns

    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30         = 34'sd1073741824;

    localparam logic signed [AW-1:0] ATAN_TURN32 [0:CORDIC_STEPS-1] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81
    };

    // slot of each index in a quad's six results
    localparam logic [2:0] SLOT_A0   = 3'd0;
    localparam logic [2:0] SLOT_B0   = 3'd1;
    localparam logic [2:0] SLOT_A1   = 3'd2;
    localparam logic [2:0] SLOT_A1B  = 3'd3;
    localparam logic [2:0] SLOT_B0B  = 3'd4;
    localparam logic [2:0] SLOT_LAST = 3'd5;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] a;
    } cordic_vec_t;

    // control word carried alongside an item through the pipeline
    typedef struct packed {
        logic        valid;
        logic        quad;
        logic        bad;
        logic        lat_neg;
        logic        flip_lon;
        logic        flip_lat;
        logic [16:0] idx_a;
        logic [16:0] idx_b;
        logic [15:0] tex_u;
        logic [16:0] tex_v;
    } ctl_t;

endpackage

`default_nettype wire

// ===== sv/uv_sphere_mesh_generator.sv =====
// ============================================================================
// uv_sphere_mesh_generator
// UV-sphere vertex and triangle-index generator with a fully pipelined
// datapath of division and CORDIC cells.
// ============================================================================
// One request enters per clock while req_stall is low. A vertex request
// (cmd 0) returns one result with position and texture coordinates; a quad
// request (cmd 1) returns six triangle indices in turn, pausing while
// rsp_stall is high; a request outside the configured grid returns one
// result with bad set. A request passes a row of restoring-division cells
// (one quotient bit per cell), a 24-cell CORDIC row, and three multiply
// stages. A quad holds the output register, and so the input, until its
// last index is sent. A stall on the result side while a result waits
// holds the whole pipeline. The user must write registers only while no
// request is in flight; the block itself does not enforce this.
`default_nettype none

module uv_sphere_mesh_generator import uvs_pkg::*; #(
    parameter int MAX_SEG_X  = 256,
    parameter int MAX_SEG_Y  = 128,
    parameter int ANGLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               cmd,
    input  logic [7:0]         ring,
    input  logic [8:0]         row,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic [15:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [16:0]        vert_index,
    output logic               last,
    output logic               bad
);

    localparam int AB     = ANGLE_BITS;
    localparam int DQW    = (AB + 1 > 17) ? AB + 1 : 17;
    localparam int NW     = DQW + 12;
    localparam int DW_LON = 10;
    localparam int DW_LAT = 11;
    localparam int DW_U   = 10;
    localparam int P_DIV  = DQW;
    localparam int P_PREP = DQW + 1;
    localparam int P_COR  = P_PREP + CORDIC_STEPS;
    localparam int P_POST = P_COR + 1;
    localparam int P_M1   = P_POST + 1;
    localparam int P_M2   = P_M1 + 1;
    localparam int P_M3   = P_M2 + 1;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [15:0] radius_reg;
    logic [8:0]  seg_x_reg;
    logic [7:0]  seg_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            seg_x_reg  <= 9'd16;
            seg_y_reg  <= 8'd8;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_RADIUS: radius_reg <= cfg_data;
                REG_SEG_X:  seg_x_reg  <= cfg_data[8:0];
                REG_SEG_Y:  seg_y_reg  <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance
    // ------------------------------------------------------------------
    logic       adv;
    logic       out_valid_reg;
    logic [2:0] cnt_reg;
    logic       quad_reg;
    logic       out_last;

    assign out_last  = !quad_reg || (cnt_reg == SLOT_LAST);
    assign adv       = !out_valid_reg || (!rsp_stall && out_last);
    assign req_stall = !adv;

    // ------------------------------------------------------------------
    // entry: range checks, quad indices, division numerators
    // ------------------------------------------------------------------
    logic              cfg_ok, vtx_ok, quad_ok;
    logic [8:0]        t_rows;
    logic [16:0]       idx_a, idx_b;
    logic signed [9:0] lat_n;
    logic [9:0]        lat_an;
    logic [NW-1:0]     n_lon, n_lat, n_u;
    logic [DW_LON-1:0] d_lon;
    logic [DW_LAT-1:0] d_lat;
    logic [DW_U-1:0]   d_u;
    ctl_t              ctl_in;

    always_comb
    begin
        cfg_ok  = (seg_x_reg >= 9'd2) && (32'(seg_x_reg) <= MAX_SEG_X)
                  && (seg_y_reg != 8'd0) && (32'(seg_y_reg) <= MAX_SEG_Y);
        vtx_ok  = !cmd && cfg_ok && ({1'b0, ring} < seg_x_reg)
                  && (row <= {seg_y_reg, 1'b0});
        quad_ok = cmd && cfg_ok && (({1'b0, ring} + 9'd1) < seg_x_reg)
                  && (row < {seg_y_reg, 1'b0});
        t_rows  = {seg_y_reg, 1'b1};
        idx_a   = 17'(row) + 17'(ring) * 17'(t_rows);
        idx_b   = idx_a + 17'(t_rows);

        lat_n   = signed'({1'b0, row}) - signed'({2'b00, seg_y_reg});
        lat_an  = lat_n[9] ? 10'(-lat_n) : 10'(lat_n);

        d_lon   = {seg_x_reg - 9'd1, 1'b0};
        d_lat   = {seg_y_reg, 3'b000};
        d_u     = {seg_x_reg, 1'b0};

        n_lon   = (NW'(ring) << (AB + 1)) + NW'(seg_x_reg - 9'd1);
        n_lat   = (NW'(lat_an) << (AB + 1)) + NW'({seg_y_reg, 2'b00});
        n_u     = (NW'(ring) << 17) + NW'(seg_x_reg);

        ctl_in          = '0;
        ctl_in.valid    = req_valid;
        ctl_in.quad     = quad_ok;
        ctl_in.bad      = !(vtx_ok || quad_ok);
        ctl_in.lat_neg  = lat_n[9];
        ctl_in.idx_a    = idx_a;
        ctl_in.idx_b    = idx_b;
    end

    // ------------------------------------------------------------------
    // control line
    // ------------------------------------------------------------------
    ctl_t ctl_reg  [0:P_M3];
    ctl_t ctl_next [0:P_M3];

    logic [DW_LON-1:0] lon_rem_reg;
    logic [DQW-1:0]    lon_low_reg;
    logic [DW_LAT-1:0] lat_rem_reg;
    logic [DQW-1:0]    lat_low_reg;
    logic [DW_U-1:0]   u_rem_reg;
    logic [DQW-1:0]    u_low_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lon_rem_reg <= n_lon[DQW +: DW_LON];
            lon_low_reg <= n_lon[DQW-1:0];
            lat_rem_reg <= n_lat[DQW +: DW_LAT];
            lat_low_reg <= n_lat[DQW-1:0];
            u_rem_reg   <= n_u[DQW +: DW_U];
            u_low_reg   <= n_u[DQW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // division rows
    // ------------------------------------------------------------------
    logic [DW_LON-1:0] lon_rem [0:DQW];
    logic [DQW-1:0]    lon_low [0:DQW];
    logic [DQW-1:0]    lon_q   [0:DQW];
    logic [DW_LAT-1:0] lat_rem [0:DQW];
    logic [DQW-1:0]    lat_low [0:DQW];
    logic [DQW-1:0]    lat_q   [0:DQW];
    logic [DW_U-1:0]   u_rem   [0:DQW];
    logic [DQW-1:0]    u_low   [0:DQW];
    logic [DQW-1:0]    u_q     [0:DQW];

    assign lon_rem[0] = lon_rem_reg;
    assign lon_low[0] = lon_low_reg;
    assign lon_q[0]   = '0;
    assign lat_rem[0] = lat_rem_reg;
    assign lat_low[0] = lat_low_reg;
    assign lat_q[0]   = '0;
    assign u_rem[0]   = u_rem_reg;
    assign u_low[0]   = u_low_reg;
    assign u_q[0]     = '0;

    for (genvar c = 0; c < DQW; c++)
    begin : g_div
        uvs_div_cell #(.DW(DW_LON), .QW(DQW)) u_lon (
            .clk     (clk),
            .en      (adv),
            .divisor (d_lon),
            .rem_in  (lon_rem[c]),
            .low_in  (lon_low[c]),
            .q_in    (lon_q[c]),
            .rem_out (lon_rem[c+1]),
            .low_out (lon_low[c+1]),
            .q_out   (lon_q[c+1])
        );
        uvs_div_cell #(.DW(DW_LAT), .QW(DQW)) u_lat (
            .clk     (clk),
            .en      (adv),
            .divisor (d_lat),
            .rem_in  (lat_rem[c]),
            .low_in  (lat_low[c]),
            .q_in    (lat_q[c]),
            .rem_out (lat_rem[c+1]),
            .low_out (lat_low[c+1]),
            .q_out   (lat_q[c+1])
        );
        uvs_div_cell #(.DW(DW_U), .QW(DQW)) u_tex (
            .clk     (clk),
            .en      (adv),
            .divisor (d_u),
            .rem_in  (u_rem[c]),
            .low_in  (u_low[c]),
            .q_in    (u_q[c]),
            .rem_out (u_rem[c+1]),
            .low_out (u_low[c+1]),
            .q_out   (u_q[c+1])
        );
    end

    // ------------------------------------------------------------------
    // angle preparation: fold into the right half plane
    // ------------------------------------------------------------------
    function automatic logic [AW:0] fold_angle(input logic [AB-1:0] q);
        logic [31:0]          t32;
        logic signed [AW-1:0] a;
        logic                 flip;
        t32  = {q, {(32-AB){1'b0}}};
        a    = signed'({t32[31], t32});
        flip = 1'b0;
        if (a > 33'sd1073741824)
        begin
            a    = a - 33'sd2147483648;
            flip = 1'b1;
        end
        else if (a < -33'sd1073741824)
        begin
            a    = a + 33'sd2147483648;
            flip = 1'b1;
        end
        return {flip, a};
    endfunction

    logic [AB-1:0]   lat_mag, lat_q_ang;
    logic [AW:0]     lon_fold, lat_fold;
    logic [15:0]     tex_u_sat;
    cordic_vec_t     lon_v [0:CORDIC_STEPS];
    cordic_vec_t     lat_v [0:CORDIC_STEPS];
    cordic_vec_t     lon_v_reg, lat_v_reg;

    always_comb
    begin
        lat_mag   = lat_q[DQW][AB-1:0];
        lat_q_ang = ctl_reg[P_DIV].lat_neg ? AB'(0) - lat_mag : lat_mag;
        lon_fold  = fold_angle(lon_q[DQW][AB-1:0]);
        lat_fold  = fold_angle(lat_q_ang);
        tex_u_sat = (u_q[DQW] > DQW'(65535)) ? 16'hFFFF : u_q[DQW][15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lon_v_reg <= '{x: CORDIC_GAIN_Q30, y: '0, a: lon_fold[AW-1:0]};
            lat_v_reg <= '{x: CORDIC_GAIN_Q30, y: '0, a: lat_fold[AW-1:0]};
        end
    end

    assign lon_v[0] = lon_v_reg;
    assign lat_v[0] = lat_v_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        uvs_cordic_cell #(.K(k)) u_lon (
            .clk   (clk),
            .en    (adv),
            .v_in  (lon_v[k]),
            .v_out (lon_v[k+1])
        );
        uvs_cordic_cell #(.K(k)) u_lat (
            .clk   (clk),
            .en    (adv),
            .v_in  (lat_v[k]),
            .v_out (lat_v[k+1])
        );
    end

    // ------------------------------------------------------------------
    // unfold, clamp, products
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] unfold(input logic signed [XW-1:0] v,
                                                  input logic flip);
        logic signed [XW-1:0] w;
        w = flip ? -v : v;
        if (w > ONE_Q30)
        begin
            w = ONE_Q30;
        end
        else if (w < -ONE_Q30)
        begin
            w = -ONE_Q30;
        end
        return 32'(w);
    endfunction

    function automatic logic signed [63:0] round30(input logic signed [63:0] v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [16:0] clamp17(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v;
        if (w > 64'sd65535)
        begin
            w = 64'sd65535;
        end
        else if (w < -64'sd65535)
        begin
            w = -64'sd65535;
        end
        return 17'(w);
    endfunction

    logic signed [31:0] cl_next, sl_next, ca_next, sa_next;
    logic signed [33:0] tv_sum, tv_shr;
    logic [16:0]        tex_v_sat;
    logic signed [31:0] cl_reg, sl_reg, ca_reg, sa_reg;
    logic signed [16:0] r_s;
    logic signed [63:0] pcx_reg, pcy_reg;
    logic signed [48:0] pz_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [16:0] z2_reg, z3_reg;
    logic signed [48:0] px_reg, py_reg;

    always_comb
    begin
        cl_next = unfold(lon_v[CORDIC_STEPS].x, ctl_reg[P_COR].flip_lon);
        sl_next = unfold(lon_v[CORDIC_STEPS].y, ctl_reg[P_COR].flip_lon);
        ca_next = unfold(lat_v[CORDIC_STEPS].x, ctl_reg[P_COR].flip_lat);
        sa_next = unfold(lat_v[CORDIC_STEPS].y, ctl_reg[P_COR].flip_lat);
        tv_sum  = 34'(sa_next) + 34'sd1073741824 + 34'sd16384;
        tv_shr  = tv_sum >>> 15;
        if (tv_shr < 0)
        begin
            tex_v_sat = '0;
        end
        else if (tv_shr > 34'sd65536)
        begin
            tex_v_sat = 17'd65536;
        end
        else
        begin
            tex_v_sat = tv_shr[16:0];
        end
        r_s = signed'({1'b0, radius_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cl_reg  <= cl_next;
            sl_reg  <= sl_next;
            ca_reg  <= ca_next;
            sa_reg  <= sa_next;
            pcx_reg <= cl_reg * ca_reg;
            pcy_reg <= sl_reg * ca_reg;
            pz_reg  <= 49'(sa_reg) * 49'(r_s);
            rx_reg  <= 32'(round30(pcx_reg));
            ry_reg  <= 32'(round30(pcy_reg));
            z2_reg  <= clamp17(round30(64'(pz_reg)));
            px_reg  <= 49'(rx_reg) * 49'(r_s);
            py_reg  <= 49'(ry_reg) * 49'(r_s);
            z3_reg  <= z2_reg;
        end
    end

    // ------------------------------------------------------------------
    // control line shifting, with fields filled in along the way
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int p = 0; p <= P_M3; p++)
        begin
            if (p == 0)
            begin
                ctl_next[p] = ctl_in;
            end
            else
            begin
                ctl_next[p] = ctl_reg[p-1];
            end
            if (p == P_PREP)
            begin
                ctl_next[p].tex_u    = tex_u_sat;
                ctl_next[p].flip_lon = lon_fold[AW];
                ctl_next[p].flip_lat = lat_fold[AW];
            end
            if (p == P_POST)
            begin
                ctl_next[p].tex_v = tex_v_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p <= P_M3; p++)
            begin
                ctl_reg[p] <= '0;
            end
        end
        else if (adv)
        begin
            for (int p = 0; p <= P_M3; p++)
            begin
                ctl_reg[p] <= ctl_next[p];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register; a quad walks through its six indices
    // ------------------------------------------------------------------
    logic               bad_reg;
    logic [16:0]        a_reg, b_reg;
    logic signed [16:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [15:0]        tex_u_reg;
    logic [16:0]        tex_v_reg;
    logic               ld_vtx;

    assign ld_vtx = !ctl_reg[P_M3].quad && !ctl_reg[P_M3].bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= SLOT_A0;
            quad_reg      <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_reg[P_M3].valid;
            cnt_reg       <= SLOT_A0;
            quad_reg      <= ctl_reg[P_M3].quad;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bad_reg   <= ctl_reg[P_M3].bad;
            a_reg     <= ctl_reg[P_M3].idx_a;
            b_reg     <= ctl_reg[P_M3].idx_b;
            pos_x_reg <= ld_vtx ? clamp17(round30(64'(px_reg))) : '0;
            pos_y_reg <= ld_vtx ? clamp17(round30(64'(py_reg))) : '0;
            pos_z_reg <= ld_vtx ? z3_reg : '0;
            tex_u_reg <= ld_vtx ? ctl_reg[P_M3].tex_u : '0;
            tex_v_reg <= ld_vtx ? ctl_reg[P_M3].tex_v : '0;
        end
    end

    always_comb
    begin
        vert_index = '0;
        if (quad_reg)
        begin
            unique case (cnt_reg)
                SLOT_A0:   vert_index = a_reg;
                SLOT_B0:   vert_index = b_reg;
                SLOT_A1:   vert_index = a_reg + 17'd1;
                SLOT_A1B:  vert_index = a_reg + 17'd1;
                SLOT_B0B:  vert_index = b_reg;
                SLOT_LAST: vert_index = b_reg + 17'd1;
                default:   vert_index = '0;
            endcase
        end
    end

    assign rsp_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;
    assign last      = out_last;
    assign bad       = bad_reg;

endmodule

`default_nettype wire

// ===== sv/uvs_div_cell.sv =====
// ============================================================================
// uvs_div_cell
// One restoring-division step: shift in one numerator bit, subtract the
// divisor when it fits, and pass remainder and quotient to the next cell.
// ============================================================================
`default_nettype none

module uvs_div_cell #(
    parameter int DW = 10,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] divisor,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] low_in,
    input  logic [QW-1:0] q_in,
    output logic [DW-1:0] rem_out,
    output logic [QW-1:0] low_out,
    output logic [QW-1:0] q_out
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] low_reg, low_next;
    logic [QW-1:0] q_reg, q_next;

    always_comb
    begin
        trial    = {rem_in, low_in[QW-1]};
        fits     = trial >= {1'b0, divisor};
        diff     = trial - {1'b0, divisor};
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        low_next = {low_in[QW-2:0], 1'b0};
        q_next   = {q_in[QW-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            q_reg   <= q_next;
        end
    end

    assign rem_out = rem_reg;
    assign low_out = low_reg;
    assign q_out   = q_reg;

endmodule

`default_nettype wire

// ===== sv/uvs_cordic_cell.sv =====
// ============================================================================
// uvs_cordic_cell
// One CORDIC rotation step in turn units: rotate toward zero residual angle
// by the step's arctangent and register the vector.
// ============================================================================
`default_nettype none

module uvs_cordic_cell import uvs_pkg::*; #(
    parameter int K = 0
) (
    input  logic        clk,
    input  logic        en,
    input  cordic_vec_t v_in,
    output cordic_vec_t v_out
);

    logic signed [XW-1:0] x_in, y_in, dx, dy;
    logic signed [AW-1:0] a_in;
    cordic_vec_t          v_reg, v_next;

    always_comb
    begin
        x_in = v_in.x;
        y_in = v_in.y;
        a_in = v_in.a;
        dx   = y_in >>> K;
        dy   = x_in >>> K;
        if (a_in >= 0)
        begin
            v_next.x = x_in - dx;
            v_next.y = y_in + dy;
            v_next.a = a_in - ATAN_TURN32[K];
        end
        else
        begin
            v_next.x = x_in + dx;
            v_next.y = y_in - dy;
            v_next.a = a_in + ATAN_TURN32[K];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
        end
    end

    assign v_out = v_reg;

endmodule

`default_nettype wire

// ===== sv/uvs_checker.sv =====
// ============================================================================
// uvs_checker
// Port-level checks of the UV-sphere mesh generator, bound to the top level.
// ============================================================================
`default_nettype none

module uvs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic signed [16:0] pos_x,
    input logic signed [16:0] pos_y,
    input logic signed [16:0] pos_z,
    input logic [15:0]        tex_u,
    input logic [16:0]        tex_v,
    input logic [16:0]        vert_index,
    input logic               last,
    input logic               bad
);

    // a stalled result stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(vert_index) && $stable(last))
        else $error("stalled result changed");

    // an out-of-grid result is a single, empty one
    a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && bad |-> last && vert_index == 17'd0 && pos_x == 17'sd0
                             && pos_z == 17'sd0 && tex_v == 17'd0)
        else $error("bad result carries data");

    // the body of a quad carries indices only
    a_quad_body: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> !bad && pos_x == 17'sd0 && pos_y == 17'sd0
                               && tex_u == 16'd0)
        else $error("quad index result carries position data");

    // the indices of a quad follow without a gap
    a_quad_burst: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !last |=> rsp_valid)
        else $error("gap inside a quad");

    // no request is taken while a quad is still being sent
    a_quad_block: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> req_stall)
        else $error("request taken during a quad");

endmodule

bind uv_sphere_mesh_generator uvs_checker u_uvs_checker (.*);

`default_nettype wire

// ===== tb/uv_sphere_mesh_generator_tb.sv =====
// ============================================================================
// UV-sphere mesh generator testbench
// Drives vertex and quad requests under several grid settings, predicts
// every result with a bit-exact fixed-point model and compares each transfer
// on the result side in order.
// ============================================================================
`timescale 1ns / 100ps

module uv_sphere_mesh_generator_tb;
    import uvs_pkg::*;

    localparam int ABITS      = 16;
    localparam int SEG_X_MAX  = 256;
    localparam int SEG_Y_MAX  = 128;
    localparam int PIPE_DEPTH = 60;
    localparam longint Q30    = 64'sd1073741824;
    localparam longint LIMIT  = 64'sd65535;

    typedef struct {
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic signed [16:0] pz;
        logic [15:0]        u;
        logic [16:0]        v;
        logic [16:0]        vi;
        logic               lst;
        logic               bd;
    } mesh_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               req_valid;
    logic               req_stall;
    logic               cmd;
    logic [7:0]         ring;
    logic [8:0]         row;
    logic               rsp_valid;
    logic               rsp_stall;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic [15:0]        tex_u;
    logic [16:0]        tex_v;
    logic [16:0]        vert_index;
    logic               last;
    logic               bad;

    mesh_result_t pending_results[$];
    int           errors;
    bit           hold_rsp;
    int           hold_cycles;
    longint       sphere_radius;
    longint       rings;
    longint       rows_half;

    uv_sphere_mesh_generator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .cmd        (cmd),
        .ring       (ring),
        .row        (row),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .tex_u      (tex_u),
        .tex_v      (tex_v),
        .vert_index (vert_index),
        .last       (last),
        .bad        (bad)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mul_round(longint a, longint b);
        return shr_floor(a * b + (Q30 >>> 1), 30);
    endfunction

    // angle in 1/2^32 turns, results in Q2.30
    function automatic void cordic_sincos(longint turn, output longint c, output longint s);
        longint a;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        a = turn;
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        flip = 0;
        if (a >= 64'sd2147483648) a -= 64'sd4294967296;
        if (a > Q30)
        begin
            a -= 64'sd2147483648;
            flip = 1;
        end
        else if (a < -Q30)
        begin
            a += 64'sd2147483648;
            flip = 1;
        end
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            dx = shr_floor(y, k);
            dy = shr_floor(x, k);
            if (a >= 0)
            begin
                x -= dx;
                y += dy;
                a -= longint'(ATAN_TURN32[k]);
            end
            else
            begin
                x += dx;
                y -= dy;
                a += longint'(ATAN_TURN32[k]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clip(x, -Q30, Q30);
        s = clip(y, -Q30, Q30);
    endfunction

    function automatic longint to_turn(longint q);
        return (q & ((64'sd1 << ABITS) - 1)) << (32 - ABITS);
    endfunction

    task automatic predict_mesh(bit c, longint i, longint j);
        mesh_result_t r;
        bit     grid_ok;
        longint d;
        longint lonq;
        longint n;
        longint an;
        longint den;
        longint mag;
        longint latq;
        longint cl;
        longint sl;
        longint ca;
        longint sa;
        longint t;
        longint ia;
        longint ib;
        longint idx[6];
        grid_ok = rings >= 2 && rings <= SEG_X_MAX && rows_half >= 1 && rows_half <= SEG_Y_MAX;
        r = '{default: 0};
        r.lst = 1;
        if (c == 1'b0 && grid_ok && i < rings && j <= 2 * rows_half)
        begin
            d = rings - 1;
            lonq = ((i << ABITS) * 2 + d) / (2 * d);
            n = j - rows_half;
            an = n < 0 ? -n : n;
            den = 4 * rows_half;
            mag = ((an << ABITS) * 2 + den) / (2 * den);
            latq = n < 0 ? (64'sd1 << ABITS) - mag : mag;
            cordic_sincos(to_turn(lonq), cl, sl);
            cordic_sincos(to_turn(latq), ca, sa);
            r.px = 17'(clip(mul_round(mul_round(cl, ca), sphere_radius), -LIMIT, LIMIT));
            r.py = 17'(clip(mul_round(mul_round(sl, ca), sphere_radius), -LIMIT, LIMIT));
            r.pz = 17'(clip(mul_round(sa, sphere_radius), -LIMIT, LIMIT));
            r.u = 16'(clip((i * 65536 * 2 + rings) / (2 * rings), 0, 65535));
            r.v = 17'(clip(shr_floor(sa + Q30 + (64'sd1 << 14), 15), 0, 65536));
            pending_results.push_back(r);
        end
        else if (c == 1'b1 && grid_ok && i + 1 < rings && j < 2 * rows_half)
        begin
            t = 2 * rows_half + 1;
            ia = j + i * t;
            ib = j + (i + 1) * t;
            idx = '{ia, ib, ia + 1, ia + 1, ib, ib + 1};
            for (int k = 0; k < 6; k++)
            begin
                r.vi = 17'(idx[k]);
                r.lst = (k == 5);
                pending_results.push_back(r);
            end
        end
        else
        begin
            r.bd = 1;
            pending_results.push_back(r);
        end
    endtask

    // rsp_stall: random short/long gaps, plus a long forced hold-off
    initial
    begin
        int gap;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                hold_cycles++;
            end
            else if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                gap--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                case ($urandom_range(0, 19))
                    0, 1, 2: gap = $urandom_range(1, 3);
                    3:       gap = $urandom_range(10, 40);
                    default: gap = 0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        mesh_result_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (pos_x !== e.px) begin $error("pos_x exp %0d got %0d", e.px, pos_x); errors++; end
                if (pos_y !== e.py) begin $error("pos_y exp %0d got %0d", e.py, pos_y); errors++; end
                if (pos_z !== e.pz) begin $error("pos_z exp %0d got %0d", e.pz, pos_z); errors++; end
                if (tex_u !== e.u) begin $error("tex_u exp %0d got %0d", e.u, tex_u); errors++; end
                if (tex_v !== e.v) begin $error("tex_v exp %0d got %0d", e.v, tex_v); errors++; end
                if (vert_index !== e.vi)
                begin
                    $error("vert_index exp %0d got %0d", e.vi, vert_index);
                    errors++;
                end
                if (last !== e.lst) begin $error("last exp %0b got %0b", e.lst, last); errors++; end
                if (bad !== e.bd) begin $error("bad exp %0b got %0b", e.bd, bad); errors++; end
            end
        end
    end

    task automatic send_request(bit c, logic [7:0] i, logic [8:0] j);
        int gap;
        gap = 0;
        case ($urandom_range(0, 19))
            0, 1, 2: gap = $urandom_range(1, 3);
            3:       gap = $urandom_range(10, 30);
            default: gap = 0;
        endcase
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd <= c;
        ring <= i;
        row <= j;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        predict_mesh(c, i, j);
    endtask

    task automatic drain_pipe();
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RADIUS: sphere_radius = longint'(val);
            REG_SEG_X:  rings = longint'(val & 16'h1FF);
            REG_SEG_Y:  rows_half = longint'(val & 16'hFF);
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [15:0] r, logic [15:0] sx, logic [15:0] sy);
        drain_pipe();
        write_reg(REG_RADIUS, r);
        write_reg(REG_SEG_X, sx);
        write_reg(REG_SEG_Y, sy);
    endtask

    task automatic test_directed();
        send_request(0, 0, 0);
        send_request(0, 0, 8);
        send_request(0, 0, 16);
        send_request(0, 15, 16);
        send_request(0, 7, 3);
        send_request(0, 16, 0);
        send_request(0, 0, 17);
        send_request(0, 8'hFF, 9'h1FF);
        send_request(1, 0, 0);
        send_request(1, 14, 15);
        send_request(1, 15, 0);
        send_request(1, 0, 16);
        send_request(1, 8'hFF, 9'h1FF);
        set_grid(16'hFFFF, 16'd256, 16'd128);
        send_request(0, 255, 256);
        send_request(0, 64, 0);
        send_request(0, 200, 77);
        send_request(1, 254, 255);
        send_request(1, 8'hAA, 9'h155);
        set_grid(16'd0, 16'd2, 16'd1);
        send_request(0, 1, 2);
        send_request(1, 0, 1);
        send_request(1, 1, 0);
        // out-of-range registers answer everything as outside the grid
        set_grid(16'h0100, 16'd1, 16'd0);
        send_request(0, 0, 0);
        send_request(1, 0, 0);
        set_grid(16'h0100, 16'h01FF, 16'h00FF);
        send_request(0, 3, 3);
    endtask

    task automatic test_random(int count);
        bit c;
        logic [7:0] i;
        logic [8:0] j;
        for (int n = 0; n < count; n++)
        begin
            c = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0)
            begin
                i = 8'($urandom);
                j = 9'($urandom);
            end
            else
            begin
                i = 8'($urandom_range(0, 32'(rings - 1)));
                j = 9'($urandom_range(0, 32'(2 * rows_half)));
            end
            send_request(c, i, j);
        end
    endtask

    // hold results back until the block backs up into its input
    task automatic test_backpressure();
        drain_pipe();
        hold_rsp = 1;
        hold_cycles = 0;
        fork
            begin
                test_random(50);
                req_valid <= 1'b0;
            end
            begin
                while (hold_cycles < 200) @(posedge clk);
                hold_rsp = 0;
            end
        join
        drain_pipe();
    endtask

    initial
    begin
        errors = 0;
        hold_rsp = 0;
        sphere_radius = 256;
        rings = 16;
        rows_half = 8;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data = '0;
        req_valid = 1'b0;
        cmd = 1'b0;
        ring = '0;
        row = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        set_grid(16'h0340, 16'd16, 16'd8);
        test_random(20);
        set_grid(16'hFFFF, 16'd256, 16'd128);
        test_random(20);
        set_grid(16'h00A5, 16'd5, 16'd3);
        test_backpressure();
        drain_pipe();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/uvs_pkg.sv
sv/uvs_div_cell.sv
sv/uvs_cordic_cell.sv
sv/uv_sphere_mesh_generator.sv
sv/uvs_checker.sv
tb/uv_sphere_mesh_generator_tb.sv
